// ===== design/okrt_pkg.sv =====
`default_nettype none

package okrt_pkg;

  localparam int ACT_W = 2;
  localparam int ID_W  = 32;
  localparam int PL_W  = 16;
  localparam int ST_W  = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // one record as held in the record memory
  typedef struct packed {
    logic [ID_W-1:0] key;
    logic [PL_W-1:0] payload;
  } rec_t;

endpackage

`default_nettype wire

// ===== design/okrt_store.sv =====
`default_nettype none

// Record memory and link memory: one write port each, one shared read
// address, registered read data (read-old on a same-cycle collision).
module okrt_store #(
  parameter  int DEPTH = 16,
  localparam int SW    = $clog2(DEPTH)
) (
  input  wire                 clk,
  input  wire                 rec_we,
  input  wire  [SW-1:0]       rec_waddr,
  input  wire okrt_pkg::rec_t rec_wdata,
  input  wire                 link_we,
  input  wire  [SW-1:0]       link_waddr,
  input  wire  [SW-1:0]       link_wdata,
  input  wire  [SW-1:0]       raddr,
  output okrt_pkg::rec_t      rec_rdata,
  output logic [SW-1:0]       link_rdata
);

  okrt_pkg::rec_t rec_mem [DEPTH];
  logic [SW-1:0]  link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata <= rec_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/ordered_keyed_ring_table_unit.sv =====
// Sequence, accept to result: append passes APPW then FIN (straight to FIN when
//   full); lookup and delete walk the slots in CMP, a delete hit then passes
//   DELW, then FIN; an empty table or unused action goes straight to FIN.
// Throughput: one transaction at a time; the next is accepted once the result
//   sits in the output register (later while out_tready holds off). The walk
//   moves one slot per cycle via the read port.
`default_nettype none

// Reset: rst_n synchronous, active low; empties the table, no clearing pass.
module ordered_keyed_ring_table_unit #(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // [31:0] record_id, [47:32] payload_handle
  input  wire  [1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [((19 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] out_tdata
  // [1:0] status, [17:2] found_payload, next CW bits entry_count,
  // then is_empty, zero fill up to a whole byte
);

  localparam int SW    = $clog2(CAPACITY);       // slot index width
  localparam int CW    = $clog2(CAPACITY + 1);   // count width
  localparam int OUT_W = ((19 + CW + 7) / 8) * 8;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_APPW = 3'd1;  // append: link the new slot
  localparam logic [2:0] S_CMP  = 3'd2;  // walk: compare one slot per cycle
  localparam logic [2:0] S_DELW = 3'd3;  // delete: free the matched slot
  localparam logic [2:0] S_FIN  = 3'd4;  // hand result to output register

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [SW-1:0] free_head_r, free_head_nxt;  // list of freed slots
  logic [CW-1:0] count_r, count_nxt;
  // slots [fresh_r, CAPACITY) have never been used; they stand in for the
  // initial free chain so the link memory needs no init sweep
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic          out_valid_r, out_valid_nxt;

  // per-transaction working registers
  logic [okrt_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [okrt_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [SW-1:0]              cur_r, cur_nxt;
  logic [SW-1:0]              prev_r, prev_nxt;
  logic [SW-1:0]              after_r, after_nxt;
  logic [CW-1:0]              n_r, n_nxt;
  logic [okrt_pkg::ST_W-1:0]  res_status_r, res_status_nxt;
  logic [okrt_pkg::PL_W-1:0]  res_pl_r, res_pl_nxt;
  logic [OUT_W-1:0]           out_data_r, out_data_nxt;

  // memory ports
  logic           rec_we;
  logic [SW-1:0]  rec_waddr;
  okrt_pkg::rec_t rec_wdata;
  logic           link_we;
  logic [SW-1:0]  link_waddr;
  logic [SW-1:0]  link_wdata;
  logic [SW-1:0]  raddr;
  okrt_pkg::rec_t rec_rd;
  logic [SW-1:0]  link_rd;

  logic                       in_fire;
  logic [okrt_pkg::ACT_W-1:0] in_act;
  logic [okrt_pkg::ID_W-1:0]  in_id;
  logic [okrt_pkg::PL_W-1:0]  in_pl;
  logic                       use_fresh;
  logic [SW-1:0]              new_slot;
  logic [OUT_W-1:0]           res_word;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign in_act     = in_tuser;
  assign in_id      = in_tdata[31:0];
  assign in_pl      = in_tdata[47:32];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a fresh slot is taken while any remain, else the freed list head
  assign use_fresh = (fresh_r < CAP_CNT);
  assign new_slot  = use_fresh ? fresh_r[SW-1:0] : free_head_r;

  okrt_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk        (clk),
    .rec_we     (rec_we),
    .rec_waddr  (rec_waddr),
    .rec_wdata  (rec_wdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .raddr      (raddr),
    .rec_rdata  (rec_rd),
    .link_rdata (link_rd)
  );

  // result packing; count and empty flag reflect the state after the op
  always_comb begin
    res_word                 = '0;
    res_word[1:0]            = res_status_r;
    res_word[17:2]           = res_pl_r;
    res_word[18 +: CW]       = count_r;
    res_word[18 + CW]        = (count_r == '0);
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_head_nxt  = free_head_r;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    act_nxt        = act_r;
    id_nxt         = id_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    after_nxt      = after_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_pl_nxt     = res_pl_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r & ~out_tready;

    rec_we     = 1'b0;
    rec_waddr  = new_slot;
    rec_wdata  = '{key: in_id, payload: in_pl};
    link_we    = 1'b0;
    link_waddr = cur_r;
    link_wdata = free_head_r;
    raddr      = cur_r;

    unique case (state_r)
      S_IDLE: begin
        // start the first read early: freed-list link for an append,
        // head slot for a walk
        raddr = (in_act == okrt_pkg::ACT_APPEND) ? free_head_r : head_r;
        if (in_fire) begin
          act_nxt    = in_act;
          id_nxt     = in_id;
          res_pl_nxt = '0;
          case (in_act) inside
            okrt_pkg::ACT_APPEND: begin
              if (count_r == CAP_CNT) begin
                res_status_nxt = okrt_pkg::ST_FULL;
                state_nxt      = S_FIN;
              end else begin
                rec_we = 1'b1;
                // old tail points at the new slot
                if (count_r != '0) begin
                  link_we    = 1'b1;
                  link_waddr = tail_r;
                  link_wdata = new_slot;
                end
                cur_nxt   = new_slot;
                state_nxt = S_APPW;
              end
            end
            okrt_pkg::ACT_DELETE, okrt_pkg::ACT_LOOKUP: begin
              if (count_r == '0) begin
                res_status_nxt = okrt_pkg::ST_MISS;
                state_nxt      = S_FIN;
              end else begin
                cur_nxt   = head_r;
                prev_nxt  = tail_r;
                n_nxt     = '0;
                state_nxt = S_CMP;
              end
            end
            default: begin
              // unused action: no change
              res_status_nxt = okrt_pkg::ST_OK;
              state_nxt      = S_FIN;
            end
          endcase
        end
      end

      S_APPW: begin
        // new slot closes the ring back to head
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = (count_r == '0) ? cur_r : head_r;
        if (use_fresh) begin
          fresh_nxt = fresh_r + CW'(1);
        end else begin
          free_head_nxt = link_rd;
        end
        if (count_r == '0) begin
          head_nxt = cur_r;
        end
        tail_nxt       = cur_r;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = okrt_pkg::ST_OK;
        state_nxt      = S_FIN;
      end

      S_CMP: begin
        raddr = link_rd;  // follow the link read with this slot
        if (rec_rd.key == id_r) begin
          if (act_r == okrt_pkg::ACT_LOOKUP) begin
            res_status_nxt = okrt_pkg::ST_OK;
            res_pl_nxt     = rec_rd.payload;
            state_nxt      = S_FIN;
          end else begin
            // bypass the matched slot
            if (count_r > CW'(1)) begin
              link_we    = 1'b1;
              link_waddr = prev_r;
              link_wdata = link_rd;
            end
            after_nxt = link_rd;
            state_nxt = S_DELW;
          end
        end else if (n_r + CW'(1) == count_r) begin
          res_status_nxt = okrt_pkg::ST_MISS;
          state_nxt      = S_FIN;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_rd;
          n_nxt    = n_r + CW'(1);
        end
      end

      S_DELW: begin
        // push freed slot on the front of the freed list
        link_we       = 1'b1;
        link_waddr    = cur_r;
        link_wdata    = free_head_r;
        free_head_nxt = cur_r;
        count_nxt     = count_r - CW'(1);
        if (count_r > CW'(1)) begin
          if (cur_r == head_r) begin
            head_nxt = after_r;
          end
          if (cur_r == tail_r) begin
            tail_nxt = prev_r;
          end
        end
        res_status_nxt = okrt_pkg::ST_OK;
        state_nxt      = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_word;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    id_r         <= id_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    after_r      <= after_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_pl_r     <= res_pl_nxt;
    out_data_r   <= out_data_nxt;
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("record count above capacity");

  a_fresh_covers: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r >= count_r)
    else $error("more records than slots ever handed out");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (n_r < count_r))
    else $error("walk ran past the last record");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish state");

endmodule

`default_nettype wire

// ===== bench/ordered_keyed_ring_table_unit_test.sv =====
`timescale 1ns / 1ps

module ordered_keyed_ring_table_unit_test;

  localparam int CAP = 16;
  localparam int CW = $clog2(CAP + 1);
  localparam int OUT_W = ((19 + CW + 7) / 8) * 8;
  // 4th action code: the unit must ignore it and still answer
  localparam logic [okrt_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RAND_PER_PHASE = 260;
  localparam int LONG_HOLD = 200;      // receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no transaction at all
  localparam int TAIL_CYCLES = CAP + 8;

  // one result transaction, field by field
  typedef struct packed {
    logic [okrt_pkg::ST_W-1:0] status;
    logic [okrt_pkg::PL_W-1:0] found;
    logic [CW-1:0]             count;
    logic                      empty;
  } ring_result_t;

  // directed stimulus row; reps > 1 steps id and payload by one per repeat
  typedef struct {
    logic [okrt_pkg::ACT_W-1:0] act;
    logic [okrt_pkg::ID_W-1:0]  id;
    logic [okrt_pkg::PL_W-1:0]  pl;
    int                         reps;
    bit                         fixed;     // expected result typed in below
    ring_result_t               fixed_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata = '0;   // [31:0] record_id, [47:32] payload_handle
  logic [1:0]        in_tuser = '0;   // [1:0] action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;       // [1:0] status, [17:2] found_payload,
                                      // then entry_count, then is_empty

  ordered_keyed_ring_table_unit #(.CAPACITY(CAP)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the ring table: slot contents, link store, free list, pointers.
  // ---------------------------------------------------------------------------
  logic [okrt_pkg::ID_W-1:0] key_mem [CAP];
  logic [okrt_pkg::PL_W-1:0] pay_mem [CAP];
  logic [3:0]      link_mem [CAP];
  logic [3:0]      head_ptr;
  logic [3:0]      tail_ptr;
  logic [3:0]      free_ptr;
  int              live_count;

  ring_result_t pending_results [$];   // expected results, oldest first
  int           mismatch_count = 0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 1'b0;

  function automatic void ring_clear();
    for (int i = 0; i < CAP; i++) begin
      key_mem[i] = '0;
      pay_mem[i] = '0;
      link_mem[i] = 4'(i + 1);   // free chain 0 -> 1 -> ... -> 15 -> 0
    end
    head_ptr = '0;
    tail_ptr = '0;
    free_ptr = '0;
    live_count = 0;
  endfunction

  // applies one transaction to the shadow and returns what the unit must answer
  function automatic ring_result_t ring_apply(input logic [okrt_pkg::ACT_W-1:0] act,
                                              input logic [okrt_pkg::ID_W-1:0] id,
                                              input logic [okrt_pkg::PL_W-1:0] pl);
    ring_result_t r;
    logic [3:0] s;
    logic [3:0] cur;
    logic [3:0] prv;
    logic [3:0] nxt;
    bit hit;
    r = '{status: okrt_pkg::ST_OK, found: '0, count: '0, empty: 1'b0};
    hit = 1'b0;
    case (act)
      okrt_pkg::ACT_APPEND: begin
        if (live_count >= CAP) begin
          r.status = okrt_pkg::ST_FULL;
        end else begin
          s = free_ptr;
          free_ptr = link_mem[s];
          key_mem[s] = id;
          pay_mem[s] = pl;
          if (live_count == 0) begin
            head_ptr = s;
            link_mem[s] = s;
          end else begin
            link_mem[s] = head_ptr;
            link_mem[tail_ptr] = s;
          end
          tail_ptr = s;
          live_count++;
        end
      end
      okrt_pkg::ACT_DELETE: begin
        cur = head_ptr;
        prv = tail_ptr;
        for (int n = 0; n < live_count && !hit; n++) begin
          if (key_mem[cur] == id) begin
            hit = 1'b1;
            nxt = link_mem[cur];
            // a lone record leaves head and tail as they were
            if (live_count > 1) begin
              link_mem[prv] = nxt;
              if (cur == head_ptr) head_ptr = nxt;
              if (cur == tail_ptr) tail_ptr = prv;
            end
            // freed slot goes to the front of the free list
            link_mem[cur] = free_ptr;
            free_ptr = cur;
            live_count--;
          end else begin
            prv = cur;
            cur = link_mem[cur];
          end
        end
        r.status = hit ? okrt_pkg::ST_OK : okrt_pkg::ST_MISS;
      end
      okrt_pkg::ACT_LOOKUP: begin
        cur = head_ptr;
        for (int n = 0; n < live_count && !hit; n++) begin
          if (key_mem[cur] == id) begin
            hit = 1'b1;
            r.found = pay_mem[cur];
          end else begin
            cur = link_mem[cur];
          end
        end
        r.status = hit ? okrt_pkg::ST_OK : okrt_pkg::ST_MISS;
      end
      default: ;   // unused code: no change
    endcase
    r.count = CW'(live_count);
    r.empty = (live_count == 0);
    return r;
  endfunction

  // id of the k-th live record counted from the head
  function automatic logic [okrt_pkg::ID_W-1:0] live_id_at(input int k);
    logic [3:0] cur;
    cur = head_ptr;
    for (int n = 0; n < k; n++) cur = link_mem[cur];
    return key_mem[cur];
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one transaction, wait for accept, record the expectation.
  // Entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_txn(input logic [okrt_pkg::ACT_W-1:0] act,
                          input logic [okrt_pkg::ID_W-1:0] id,
                          input logic [okrt_pkg::PL_W-1:0] pl, input bit fixed,
                          input ring_result_t fixed_res);
    ring_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {pl, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = ring_apply(act, id, pl);
    pending_results.push_back(fixed ? fixed_res : predicted);
    @(negedge clk);
  endtask

  // stop offering and wait for every expected result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, or one long hold-off when asked.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.found  = out_tdata[17:2];
      got.count  = out_tdata[18 +: CW];
      got.empty  = out_tdata[18 + CW];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(got), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.found !== want.found)
          report_mismatch("found_payload", 32'(got.found), 32'(want.found));
        if (got.count !== want.count)
          report_mismatch("entry_count", 32'(got.count), 32'(want.count));
        if (got.empty !== want.empty)
          report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
      end
    end
  end

  // watchdog: too long with no transaction on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $realtime, quiet_cycles);
      $display("[ordered_keyed_ring_table_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t plan [$];
  logic [okrt_pkg::ID_W-1:0] id_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                             32'h8000_0000, 32'h7FFF_FFFF,
                                             32'h0000_0001, 32'h1234_5678};

  initial begin
    ring_result_t none;
    int stall_sets [4][2];
    bit filling;
    int r;
    logic [okrt_pkg::ACT_W-1:0] act;
    logic [okrt_pkg::ID_W-1:0]  id;
    logic [okrt_pkg::PL_W-1:0]  pl;

    none = '{status: okrt_pkg::ST_OK, found: '0, count: '0, empty: 1'b0};
    ring_clear();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, lone record, duplicates, head/tail deletes, full
    plan.push_back('{okrt_pkg::ACT_LOOKUP, 32'h0000_0000, 16'h0000, 1, 1'b1,
                     '{okrt_pkg::ST_MISS, 16'h0000, 5'd0, 1'b1}});
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'hFFFF_FFFF, 16'h0000, 1, 1'b1,
                     '{okrt_pkg::ST_MISS, 16'h0000, 5'd0, 1'b1}});
    plan.push_back('{ACT_UNUSED, 32'h5A5A_5A5A, 16'hFFFF, 1, 1'b1,
                     '{okrt_pkg::ST_OK, 16'h0000, 5'd0, 1'b1}});
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'h8000_0000, 16'hFFFF, 1, 1'b1,
                     '{okrt_pkg::ST_OK, 16'h0000, 5'd1, 1'b0}});
    plan.push_back('{okrt_pkg::ACT_LOOKUP, 32'h8000_0000, 16'h0000, 1, 1'b1,
                     '{okrt_pkg::ST_OK, 16'hFFFF, 5'd1, 1'b0}});
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'h8000_0000, 16'h0000, 1, 1'b1,
                     '{okrt_pkg::ST_OK, 16'h0000, 5'd0, 1'b1}});
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'h7FFF_FFFF, 16'h0000, 1, 1'b1,
                     '{okrt_pkg::ST_OK, 16'h0000, 5'd1, 1'b0}});
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'hFFFF_FFFF, 16'hAAAA, 1, 1'b0, none});
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'h0000_0000, 16'h5555, 1, 1'b0, none});
    // duplicate id
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'h7FFF_FFFF, 16'h1234, 1, 1'b0, none});
    // first match
    plan.push_back('{okrt_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1, 1'b0, none});
    // head
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'h7FFF_FFFF, 16'h0000, 1, 1'b0, none});
    // the copy
    plan.push_back('{okrt_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1, 1'b0, none});
    // absent
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'h1234_ABCD, 16'h0000, 1, 1'b0, none});
    // tail
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'h7FFF_FFFF, 16'h0000, 1, 1'b0, none});
    plan.push_back('{ACT_UNUSED, 32'hA5A5_A5A5, 16'h0F0F, 1, 1'b0, none});
    // fill up
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'h0000_0100, 16'h0200, 14, 1'b0, none});
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'h1234_5678, 16'hBEEF, 1, 1'b1,
                     '{okrt_pkg::ST_FULL, 16'h0000, 5'd16, 1'b0}});
    plan.push_back('{okrt_pkg::ACT_LOOKUP, 32'h0000_0105, 16'h0000, 1, 1'b0, none});
    // tail
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'h0000_010D, 16'h0000, 1, 1'b0, none});
    // head
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'hFFFF_FFFF, 16'h0000, 1, 1'b0, none});
    // reused slot
    plan.push_back('{okrt_pkg::ACT_APPEND, 32'h0000_4242, 16'h8001, 1, 1'b0, none});
    plan.push_back('{okrt_pkg::ACT_LOOKUP, 32'h0000_4242, 16'h0000, 1, 1'b0, none});
    plan.push_back('{okrt_pkg::ACT_DELETE, 32'h0000_0000, 16'h0000, 1, 1'b0, none});
    plan.push_back('{okrt_pkg::ACT_LOOKUP, 32'hDEAD_BEEF, 16'h0000, 1, 1'b0, none});

    foreach (plan[i]) begin
      for (int j = 0; j < plan[i].reps; j++) begin
        send_txn(plan[i].act, plan[i].id + okrt_pkg::ID_W'(j),
                 plan[i].pl + okrt_pkg::PL_W'(j), plan[i].fixed, plan[i].fixed_res);
      end
    end

    // random phases: {sender idle %, receiver stall %}
    stall_sets = '{'{0, 0}, '{79, 0}, '{0, 79}, '{24, 24}};
    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      // sender pause: every expected result in before the idling changes
      wait_drained();
      send_idle_pct = stall_sets[ph][0];
      recv_stall_pct = stall_sets[ph][1];
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 0 && (k == 60 || k == 180)) hold_request = 1'b1;

        if (live_count == CAP && $urandom_range(0, 2) == 0) filling = 1'b0;
        if (live_count == 0) filling = 1'b1;

        r = $urandom_range(0, 99);
        if (r < 3) begin
          act = ACT_UNUSED;
        end else if (r < (filling ? 68 : 18)) begin
          act = okrt_pkg::ACT_APPEND;
        end else if (r < (filling ? 83 : 68)) begin
          act = okrt_pkg::ACT_DELETE;
        end else begin
          act = okrt_pkg::ACT_LOOKUP;
        end

        r = $urandom_range(0, 99);
        if (act == okrt_pkg::ACT_APPEND) begin
          // pool ids and copies of live ids make duplicates
          if (r < 30) id = id_pool[$urandom_range(0, 5)];
          else if (r < 50 && live_count > 0) id = live_id_at($urandom_range(0, live_count - 1));
          else id = $urandom;
        end else if (r < 80 && live_count > 0) begin
          id = live_id_at($urandom_range(0, live_count - 1));
        end else if (r < 90) begin
          id = id_pool[$urandom_range(0, 5)];
        end else begin
          id = $urandom;
        end

        r = $urandom_range(0, 9);
        pl = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : okrt_pkg::PL_W'($urandom);
        send_txn(act, id, pl, 1'b0, none);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ordered_keyed_ring_table_unit] OK");
    end else begin
      $display("[ordered_keyed_ring_table_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/okrt_pkg.sv
design/okrt_store.sv
design/ordered_keyed_ring_table_unit.sv
bench/ordered_keyed_ring_table_unit_test.sv
